// ----- src/bsd_pkg.sv -----
`timescale 1ns / 1ps
// bsd_pkg: beat types, decoder modes and character constants for the
// backslash escape decoder. No dependencies.
package bsd_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_beat_t;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_SLASH = 2'd1,
		MODE_OCT   = 2'd2,
		MODE_HEX   = 2'd3
	} mode_t;

	// results of one input byte, zero to two beats
	typedef struct packed {
		logic [1:0]             n;
		out_beat_t [1:0]        beat;
	} res_t;

	typedef struct packed {
		logic push;
		res_t res;
	} push_t;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_SEVEN     = 8'h37;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_LC_A      = 8'h61;
	localparam logic [7:0] CH_LC_F      = 8'h66;
	localparam logic [7:0] CH_UC_A      = 8'h41;
	localparam logic [7:0] CH_UC_F      = 8'h46;
	localparam logic [1:0] MAX_BEATS    = 2'd2;

	// {valid, value} of a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				t = c - CH_ZERO;
				hex_digit = {1'b1, t[3:0]};
			end else if (c >= CH_LC_A && c <= CH_LC_F) begin
				t = c - CH_LC_A + 8'd10;
				hex_digit = {1'b1, t[3:0]};
			end else if (c >= CH_UC_A && c <= CH_UC_F) begin
				t = c - CH_UC_A + 8'd10;
				hex_digit = {1'b1, t[3:0]};
			end else begin
				hex_digit = 5'd0;
			end
		end
	endfunction

endpackage

// ----- src/bsd_core.sv -----
`timescale 1ns / 1ps
// bsd_core: input register, escape state and the one-pass decode of a byte.
// Depends on bsd_pkg.
module bsd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              escapes_enabled,
	input  logic              in_valid,
	output logic              in_stall,
	input  bsd_pkg::in_beat_t in_data,
	input  logic [1:0]        space,
	output bsd_pkg::push_t    push
);
	import bsd_pkg::*;

	logic       valid_s1;
	in_beat_t   data_s1;
	mode_t      mode_q, mode_d;
	logic [1:0] dcnt_q, dcnt_d;
	logic [8:0] pend_q, pend_d;
	res_t       res;
	logic       fire;

	function automatic res_t add_beat(input res_t r, input logic [7:0] b);
		res_t t;
		begin
			t = r;
			if (t.n == 2'd0) begin
				t.beat[0] = '{out_byte: b, run_last: 1'b0};
			end else begin
				t.beat[1] = '{out_byte: b, run_last: 1'b0};
			end
			t.n = t.n + 2'd1;
			add_beat = t;
		end
	endfunction

	always_comb begin
		logic [7:0] c;
		logic [4:0] hd;
		logic [8:0] nv;
		logic [1:0] nc;
		c = data_s1.in_byte;
		hd = hex_digit(c);
		nv = 9'd0;
		nc = 2'd0;
		res = '0;
		mode_d = mode_q;
		dcnt_d = dcnt_q;
		pend_d = pend_q;
		if (!escapes_enabled) begin
			res = add_beat(res, c);
			mode_d = MODE_PLAIN;
			dcnt_d = 2'd0;
			pend_d = 9'd0;
		end else begin
			case (mode_q)
				MODE_PLAIN: begin
					if (c == CH_BACKSLASH) mode_d = MODE_SLASH;
					else res = add_beat(res, c);
				end
				MODE_SLASH: begin
					dcnt_d = 2'd0;
					pend_d = 9'd0;
					if (c == CH_BACKSLASH) begin
						res = add_beat(res, CH_BACKSLASH);
						mode_d = MODE_PLAIN;
					end else if (c == CH_N) begin
						res = add_beat(res, CH_NEWLINE);
						mode_d = MODE_PLAIN;
					end else if (c == CH_ZERO) begin
						mode_d = MODE_OCT;
					end else if (c == CH_X) begin
						mode_d = MODE_HEX;
					end else begin
						res = add_beat(res, c);
						mode_d = MODE_PLAIN;
					end
				end
				MODE_OCT: begin
					if (c >= CH_ZERO && c <= CH_SEVEN) begin
						nv = {pend_q[5:0], c[2:0]};
						nc = dcnt_q + 2'd1;
						pend_d = nv;
						dcnt_d = nc;
						if (nc == 2'd3) begin
							res = add_beat(res, nv[7:0]);
							mode_d = MODE_PLAIN;
							dcnt_d = 2'd0;
							pend_d = 9'd0;
						end
					end else begin
						res = add_beat(res, pend_q[7:0]);
						res = add_beat(res, c);
						mode_d = MODE_PLAIN;
						dcnt_d = 2'd0;
						pend_d = 9'd0;
					end
				end
				MODE_HEX: begin
					if (hd[4]) begin
						nv = {pend_q[4:0], hd[3:0]};
						nc = dcnt_q + 2'd1;
						pend_d = nv;
						dcnt_d = nc;
						if (nc >= 2'd2) begin
							res = add_beat(res, nv[7:0]);
							mode_d = MODE_PLAIN;
							dcnt_d = 2'd0;
							pend_d = 9'd0;
						end
					end else begin
						res = add_beat(res, pend_q[7:0]);
						res = add_beat(res, c);
						mode_d = MODE_PLAIN;
						dcnt_d = 2'd0;
						pend_d = 9'd0;
					end
				end
				default: mode_d = MODE_PLAIN;
			endcase
			// end of argument: flush what is pending
			if (data_s1.in_last) begin
				if (mode_d == MODE_SLASH) res = add_beat(res, CH_BACKSLASH);
				else if (mode_d == MODE_OCT || mode_d == MODE_HEX)
					res = add_beat(res, pend_d[7:0]);
				mode_d = MODE_PLAIN;
				dcnt_d = 2'd0;
				pend_d = 9'd0;
			end
		end
		if (res.n == MAX_BEATS) res.beat[1].run_last = 1'b1;
		else if (res.n == 2'd1) res.beat[0].run_last = 1'b1;
	end

	// space comes from registered queue count only
	assign fire     = valid_s1 && (res.n <= space);
	assign in_stall = valid_s1 && !fire;
	assign push     = '{push: fire, res: res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_PLAIN;
			dcnt_q   <= 2'd0;
			pend_q   <= 9'd0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (fire) begin
				mode_q <= mode_d;
				dcnt_q <= dcnt_d;
				pend_q <= pend_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) data_s1 <= in_data;
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && data_s1.in_last |=> mode_q == MODE_PLAIN && pend_q == 9'd0)
		else $error("state not cleared after end of argument");
	a_plain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !escapes_enabled |=> mode_q == MODE_PLAIN && dcnt_q == 2'd0)
		else $error("pass-through left escape state");
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res.n > space)
		else $error("stall without a held byte lacking room");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_OCT || mode_q == MODE_HEX || dcnt_q == 2'd0)
		else $error("digit count outside a numeric escape");

endmodule

// ----- src/bsd_outq.sv -----
`timescale 1ns / 1ps
// bsd_outq: two-entry result queue that takes up to two beats per cycle
// and hands out one while out_stall is low. Depends on bsd_pkg.
module bsd_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  bsd_pkg::push_t     push,
	output logic [1:0]         space,
	output logic               out_valid,
	input  logic               out_stall,
	output bsd_pkg::out_beat_t out_data
);
	import bsd_pkg::*;

	out_beat_t  ent_q [2];
	out_beat_t  ent_d [2];
	logic [1:0] cnt_q, cnt_d, cnt_pop;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[0];
	assign pop       = out_valid && !out_stall;
	assign space     = MAX_BEATS - cnt_q;
	assign cnt_pop   = cnt_q - {1'b0, pop};

	always_comb begin
		ent_d[0] = pop ? ent_q[1] : ent_q[0];
		ent_d[1] = ent_q[1];
		cnt_d    = cnt_pop;
		if (push.push && push.res.n != 2'd0) begin
			if (cnt_pop == 2'd0) ent_d[0] = push.res.beat[0];
			else ent_d[1] = push.res.beat[0];
			if (push.res.n == MAX_BEATS) ent_d[1] = push.res.beat[1];
			cnt_d = cnt_pop + push.res.n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else cnt_q <= cnt_d;
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= ent_d[0];
		ent_q[1] <= ent_d[1];
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_BEATS)
		else $error("result queue over capacity");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> {1'b0, cnt_pop} + {1'b0, push.res.n} <= {1'b0, MAX_BEATS})
		else $error("push overruns result queue");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !(push.push && push.res.n != 2'd0) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("popped beat not removed");

endmodule

// ----- src/backslash_escape_decoder.sv -----
`timescale 1ns / 1ps
// backslash_escape_decoder: top level, escape enable register plus the
// decode core and result queue. Depends on bsd_pkg, bsd_core, bsd_outq.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid / in_stall     in_data  (in_byte, in_last)
//   out      from block out_valid / out_stall   out_data (out_byte, run_last)
//   cfg      to block   cfg_valid / cfg_ready   cfg_data (escapes_enabled)
//
// One input byte per cycle while in_stall is low; a byte is decoded in a single
// pass between the input register and a two-entry result queue, and its results
// are registered in the queue before they can be taken. Queue room is judged from
// the registered count: a byte with two results waits for the queue to empty,
// and a following byte with any result waits for one of those beats to leave.
// Reset returns to plain text with escapes disabled; cfg_ready is always high.
module backslash_escape_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bsd_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bsd_pkg::out_beat_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import bsd_pkg::*;

	logic       escapes_q;
	logic [1:0] space;
	push_t      push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) escapes_q <= 1'b0;
		else if (cfg_valid && cfg_ready) escapes_q <= cfg_data;
	end

	bsd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.escapes_enabled (escapes_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.space           (space),
		.push            (push)
	);

	bsd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
